// ===== rtl/clcd_pkg.sv =====
`default_nettype none

package clcd_pkg;

	// Default geometry of the display.
	localparam int unsigned DEF_COLUMNS = 16;
	localparam int unsigned DEF_ROWS    = 2;

	// Register reset values.
	localparam logic [7:0] RST_INIT_DELAY   = 8'd20;
	localparam logic [7:0] RST_FUNCTION_SET = 8'd56;
	localparam logic [7:0] RST_CURSOR_SETUP = 8'd14;
	localparam logic [7:0] RST_CLEAR        = 8'd1;
	localparam logic [7:0] RST_CURSOR_BASE  = 8'd128;
	localparam logic [2:0] RST_ROW_SHIFT    = 3'd6;

	// Init phases: even phases raise E with an init command, odd ones drop it.
	localparam logic [2:0] PH_FUNCTION_SET = 3'd0;
	localparam logic [2:0] PH_CURSOR_SETUP = 3'd2;
	localparam logic [2:0] PH_CLEAR        = 3'd4;
	localparam logic [2:0] PH_DONE         = 3'd6;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_DATA   = 2'd1,
		ACT_CMD    = 2'd2,
		ACT_CURSOR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_INIT_DELAY   = 3'd0,
		CFG_FUNCTION_SET = 3'd1,
		CFG_CURSOR_SETUP = 3'd2,
		CFG_CLEAR        = 3'd3,
		CFG_CURSOR_BASE  = 3'd4,
		CFG_ROW_SHIFT    = 3'd5
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/clcd_byte_buf.sv =====
`default_nettype none

module clcd_byte_buf #(
	parameter int unsigned DEPTH = clcd_pkg::DEF_COLUMNS
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [7:0]                             wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [7:0]                             rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A write to the address being read is passed straight through, so the
	// read register always mirrors the entry at the read address it last sampled.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_write_sequencer_core.sv =====
// Character LCD write sequencer for an 8-bit HD44780-style bus.
// Items arrive on the input channel (in_valid/in_ready): a tick, one byte of a
// data string, a command request or a cursor position request. Every accepted
// item produces exactly one result on the output channel (out_valid/out_ready)
// carrying the accept flag, the pin levels RS, RW, E and D7..D0, busy and
// init_done as they stand after that item.
// The result of an item is presented the cycle after its transfer. Throughput
// is one item per cycle while results are taken; the only storage in the path
// is the result register, and the byte buffer is read ahead of use.
// When the receiver stalls, the result register holds its contents and
// in_ready stays low until the result has been taken.
// Configuration is written through cfg_write/cfg_index/cfg_data with no wait
// and should only be written while the block is idle.
// Reset (arst_n low) restores the register defaults, clears all control state
// and restarts the power-up delay; no clearing pass is needed afterwards.
`default_nettype none

module char_lcd_write_sequencer_core #(
	parameter int unsigned COLUMNS = clcd_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = clcd_pkg::DEF_ROWS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_write,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic [2:0] row,
	input  wire logic [4:0] column,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            accepted,
	output logic            lcd_rs,
	output logic            lcd_rw,
	output logic            lcd_e,
	output logic [7:0]      lcd_data,
	output logic            busy_res,
	output logic            init_done
);

	localparam int unsigned IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned CNT_W = $clog2(COLUMNS + 1);
	localparam logic [CNT_W-1:0] COLS_CNT = CNT_W'(COLUMNS);

	// Configuration registers.
	logic [7:0] function_set_q;
	logic [7:0] cursor_setup_q;
	logic [7:0] clear_q;
	logic [7:0] cursor_base_q;
	logic [2:0] row_shift_q;

	// Sequencer state.
	logic [2:0]       phase_q, phase_d;
	logic [7:0]       delay_q, delay_d;
	logic             e_q, e_d;
	logic             busy_q, busy_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic [CNT_W-1:0] wr_idx_q, wr_idx_d;
	logic             cmd_pend_q, cmd_pend_d;
	logic [7:0]       cmd_code_q, cmd_code_d;
	logic             rs_q, rs_d;
	logic [7:0]       bus_q, bus_d;

	logic             in_fire;
	logic             ok;
	logic             pos_ok;
	logic [7:0]       cursor_code;
	logic             mem_we;
	logic [7:0]       mem_rd;
	logic             done_d;

	assign in_fire = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;

	assign pos_ok = (int'(row) < ROWS) && (int'(column) < COLUMNS);
	assign cursor_code = cursor_base_q | ({5'b0, row} << row_shift_q) | {3'b0, column};

	clcd_byte_buf #(
		.DEPTH (COLUMNS)
	) u_buf (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (data_byte),
		.rd_addr (wr_idx_d[IDX_W-1:0]),
		.rd_data (mem_rd)
	);

	always_comb begin
		phase_d    = phase_q;
		delay_d    = delay_q;
		e_d        = e_q;
		busy_d     = busy_q;
		fill_d     = fill_q;
		total_d    = total_q;
		wr_idx_d   = wr_idx_q;
		cmd_pend_d = cmd_pend_q;
		cmd_code_d = cmd_code_q;
		rs_d       = rs_q;
		bus_d      = bus_q;
		ok         = 1'b1;
		mem_we     = 1'b0;

		if (in_fire) begin
			unique case (clcd_pkg::action_t'(action))
				clcd_pkg::ACT_TICK: begin
					if (phase_q >= clcd_pkg::PH_DONE) begin
						if (e_q) begin
							e_d = 1'b0;
						end else if (cmd_pend_q) begin
							rs_d       = 1'b0;
							bus_d      = cmd_code_q;
							e_d        = 1'b1;
							cmd_pend_d = 1'b0;
						end else if ((wr_idx_q < total_q) && (wr_idx_q < COLS_CNT)) begin
							rs_d     = 1'b1;
							bus_d    = mem_rd;
							e_d      = 1'b1;
							wr_idx_d = wr_idx_q + 1'b1;
						end else if (busy_q) begin
							busy_d   = 1'b0;
							total_d  = '0;
							wr_idx_d = '0;
						end
					end else if (delay_q != 8'd0) begin
						delay_d = delay_q - 8'd1;
					end else begin
						unique case (phase_q)
							clcd_pkg::PH_FUNCTION_SET: begin
								rs_d  = 1'b0;
								bus_d = function_set_q;
								e_d   = 1'b1;
							end
							clcd_pkg::PH_CURSOR_SETUP: begin
								rs_d  = 1'b0;
								bus_d = cursor_setup_q;
								e_d   = 1'b1;
							end
							clcd_pkg::PH_CLEAR: begin
								rs_d  = 1'b0;
								bus_d = clear_q;
								e_d   = 1'b1;
							end
							default: begin
								e_d = 1'b0;
							end
						endcase
						phase_d = phase_q + 3'd1;
					end
				end
				clcd_pkg::ACT_DATA: begin
					if (busy_q) begin
						ok = 1'b0;
					end else if (fill_q >= COLS_CNT) begin
						// Overflow discards the partial string.
						fill_d = '0;
						ok     = 1'b0;
					end else begin
						mem_we = 1'b1;
						fill_d = fill_q + 1'b1;
						if (last_byte) begin
							total_d  = fill_q + 1'b1;
							wr_idx_d = '0;
							fill_d   = '0;
							busy_d   = 1'b1;
						end
					end
				end
				clcd_pkg::ACT_CMD: begin
					if (busy_q) begin
						ok = 1'b0;
					end else begin
						cmd_code_d = data_byte;
						fill_d     = '0;
						cmd_pend_d = 1'b1;
						busy_d     = 1'b1;
					end
				end
				clcd_pkg::ACT_CURSOR: begin
					if (!pos_ok || busy_q) begin
						ok = 1'b0;
					end else begin
						cmd_code_d = cursor_code;
						fill_d     = '0;
						cmd_pend_d = 1'b1;
						busy_d     = 1'b1;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end

		// A new delay takes effect at once while the power-up wait is running.
		if (cfg_write && (cfg_index == clcd_pkg::CFG_INIT_DELAY)
				&& (phase_q == clcd_pkg::PH_FUNCTION_SET)) begin
			delay_d = cfg_data;
		end
	end

	assign done_d = (phase_d >= clcd_pkg::PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_set_q <= clcd_pkg::RST_FUNCTION_SET;
			cursor_setup_q <= clcd_pkg::RST_CURSOR_SETUP;
			clear_q        <= clcd_pkg::RST_CLEAR;
			cursor_base_q  <= clcd_pkg::RST_CURSOR_BASE;
			row_shift_q    <= clcd_pkg::RST_ROW_SHIFT;
		end else if (cfg_write) begin
			unique case (clcd_pkg::cfg_reg_t'(cfg_index))
				// The delay value only matters as the countdown, loaded above.
				clcd_pkg::CFG_INIT_DELAY: begin
				end
				clcd_pkg::CFG_FUNCTION_SET: function_set_q <= cfg_data;
				clcd_pkg::CFG_CURSOR_SETUP: cursor_setup_q <= cfg_data;
				clcd_pkg::CFG_CLEAR:        clear_q        <= cfg_data;
				clcd_pkg::CFG_CURSOR_BASE:  cursor_base_q  <= cfg_data;
				clcd_pkg::CFG_ROW_SHIFT:    row_shift_q    <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= clcd_pkg::PH_FUNCTION_SET;
			delay_q    <= clcd_pkg::RST_INIT_DELAY;
			e_q        <= 1'b0;
			busy_q     <= 1'b0;
			fill_q     <= '0;
			total_q    <= '0;
			wr_idx_q   <= '0;
			cmd_pend_q <= 1'b0;
			rs_q       <= 1'b0;
			bus_q      <= 8'd0;
		end else begin
			phase_q    <= phase_d;
			delay_q    <= delay_d;
			e_q        <= e_d;
			busy_q     <= busy_d;
			fill_q     <= fill_d;
			total_q    <= total_d;
			wr_idx_q   <= wr_idx_d;
			cmd_pend_q <= cmd_pend_d;
			rs_q       <= rs_d;
			bus_q      <= bus_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_code_q <= cmd_code_d;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			accepted  <= ok;
			lcd_rs    <= rs_d;
			lcd_e     <= e_d;
			lcd_data  <= bus_d;
			busy_res  <= busy_d;
			init_done <= done_d;
		end
	end

	assign lcd_rw = 1'b0;

`ifndef SYNTHESIS
	a_wr_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= total_q)
		else $error("write index ran past the string length");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!cmd_pend_q && (total_q == '0)))
		else $error("work pending while not busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= COLS_CNT)
		else $error("fill count beyond buffer depth");

	a_reject_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !ok) |=> (busy_q == $past(busy_q)))
		else $error("rejected request changed busy");
`endif

endmodule

`default_nettype wire
